### rtl/interval_merge_table_top_defines.svh
// Assertion macros shared by the interval merge table RTL.
`ifndef INTERVAL_MERGE_TABLE_TOP_DEFINES_SVH
`define INTERVAL_MERGE_TABLE_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define IMT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another in the same cycle.
`define IMT_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define IMT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/imt_pkg.sv
// Shared constants and types of the interval merge table.
package imt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_AW      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 * TABLE_DEPTH;

    // Field widths
    localparam int ADDR_W      = 64;
    localparam int ENTRY_W     = 2 * ADDR_W;
    localparam int USED_W      = 5;
    localparam int MODE_W      = 2;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_PAD_W   = OUT_TDATA_W - USED_W - 2 * ADDR_W;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

    // Compare flags from the merge unit
    typedef struct packed {
        logic touch;   // entry overlaps or abuts the working range
        logic ent_lt;  // entry start lies below the working start
    } t_merge_res;

endpackage

### rtl/imt_ram.sv
// Generic simple dual-port RAM with registered read.
module imt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, holds its data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/imt_merge_unit.sv
// Shared compare and merge unit: one stored entry against the working range.
module imt_merge_unit
    import imt_pkg::*;
(
    input  logic [ADDR_W-1:0] i_cur_s,
    input  logic [ADDR_W-1:0] i_cur_e,
    input  logic [ADDR_W-1:0] i_ent_s,
    input  logic [ADDR_W-1:0] i_ent_e,
    output t_merge_res        o_res,
    output logic [ADDR_W-1:0] o_mrg_s,
    output logic [ADDR_W-1:0] o_mrg_e
);

    logic ent_lt;
    logic ent_gt;

    // Compare bounds; touching counts as overlap
    assign ent_lt       = i_ent_s < i_cur_s;
    assign ent_gt       = i_ent_e > i_cur_e;
    assign o_res.touch  = (i_ent_s <= i_cur_e) && (i_ent_e >= i_cur_s);
    assign o_res.ent_lt = ent_lt;

    // Widen the working range to cover the entry
    assign o_mrg_s = ent_lt ? i_ent_s : i_cur_s;
    assign o_mrg_e = ent_gt ? i_ent_e : i_cur_e;

endmodule

### rtl/interval_merge_table_top.sv
// Interval merge table top level: stream ports, sequencer and result register.
//
// The block keeps up to TABLE_DEPTH disjoint ranges sorted by start in a
// two-bank RAM and takes one item at a time (o_s_tready is high only while
// the sequencer is idle). An insert runs two scans: a first scan reads every
// entry once to find the merged range, a second scan copies the kept entries
// and the merged one in order into the other bank, and each entry read takes
// a read state and an evaluate state because the RAM read is registered. An
// insert dropped for a full table runs only the first scan, and one with zero
// length or end overflow runs neither. A readout gives one result per stored
// range. A stalled result side holds the sequencer in its readout and result
// states. All compares go through one shared merge unit. The result register
// lets the next item enter while a result waits for o_m_tready.
`include "interval_merge_table_top_defines.svh"

module interval_merge_table_top
    import imt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tdata: range_start [63:0], range_length [127:64]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: mode [1:0]
    input  logic [MODE_W-1:0]      i_s_tuser,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: out_start [63:0], out_length [127:64], used_entries [132:128], zeros
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // tuser: status [1:0]
    output logic [STAT_W-1:0]      o_m_tuser,
    output logic                   o_m_tlast,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1_RD,
        ST_P1_EV,
        ST_DECIDE,
        ST_P2_RD,
        ST_P2_EV,
        ST_FINISH,
        ST_RO_RD,
        ST_RO_EV,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;

    logic              r_bank, n_bank;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_w, n_w;
    logic [ADDR_W-1:0] r_cur_s, n_cur_s;
    logic [ADDR_W-1:0] r_cur_e, n_cur_e;
    logic              r_absorbed, n_absorbed;
    logic              r_inserted, n_inserted;
    logic [STAT_W-1:0] r_st, n_st;

    logic              r_o_valid, n_o_valid;
    logic [STAT_W-1:0] r_o_st, n_o_st;
    logic [ADDR_W-1:0] r_o_start, n_o_start;
    logic [ADDR_W-1:0] r_o_len, n_o_len;
    logic              r_o_last, n_o_last;
    logic [USED_W-1:0] r_o_used, n_o_used;

    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [ADDR_W-1:0] in_start;
    logic [ADDR_W-1:0] in_len;
    logic [ADDR_W:0]   in_sum;
    logic [ADDR_W-1:0] ent_s;
    logic [ADDR_W-1:0] ent_e;
    t_merge_res        mres;
    logic [ADDR_W-1:0] mrg_s;
    logic [ADDR_W-1:0] mrg_e;
    logic              out_free;
    logic              ro_last;

    // Unpack the input item and the RAM entry
    assign in_start = i_s_tdata[ADDR_W-1:0];
    assign in_len   = i_s_tdata[2*ADDR_W-1:ADDR_W];
    assign in_sum   = {1'b0, in_start} + {1'b0, in_len};
    assign ent_s    = rd_data[ADDR_W-1:0];
    assign ent_e    = rd_data[ENTRY_W-1:ADDR_W];

    assign o_s_tready = (r_state == ST_IDLE);
    assign out_free   = !r_o_valid || i_m_tready;
    assign ro_last    = (r_i + CNT_W'(1)) == r_count;

    imt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    imt_merge_unit u_merge (
        .i_cur_s (r_cur_s),
        .i_cur_e (r_cur_e),
        .i_ent_s (ent_s),
        .i_ent_e (ent_e),
        .o_res   (mres),
        .o_mrg_s (mrg_s),
        .o_mrg_e (mrg_e)
    );

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_count    = r_count;
        n_i        = r_i;
        n_w        = r_w;
        n_cur_s    = r_cur_s;
        n_cur_e    = r_cur_e;
        n_absorbed = r_absorbed;
        n_inserted = r_inserted;
        n_st       = r_st;
        n_o_valid  = r_o_valid;
        n_o_st     = r_o_st;
        n_o_start  = r_o_start;
        n_o_len    = r_o_len;
        n_o_last   = r_o_last;
        n_o_used   = r_o_used;
        rd_en      = 1'b0;
        rd_addr    = {r_bank, r_i[IDX_W-1:0]};
        wr_en      = 1'b0;
        wr_addr    = {~r_bank, r_w[IDX_W-1:0]};
        wr_data    = {r_cur_e, r_cur_s};

        // Retire the result on a transfer
        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_s_tuser)
                        MODE_INSERT: begin
                            n_cur_s    = in_start;
                            n_cur_e    = in_sum[ADDR_W-1:0];
                            n_i        = '0;
                            n_absorbed = 1'b0;
                            if (in_len == '0) begin
                                n_st    = STAT_OK;
                                n_state = ST_EMIT;
                            end else if (in_sum[ADDR_W]) begin
                                n_st    = STAT_OVF;
                                n_state = ST_EMIT;
                            end else begin
                                n_state = ST_P1_RD;
                            end
                        end
                        MODE_READ: begin
                            n_i = '0;
                            if (r_count == '0) begin
                                n_st    = STAT_EMPTY;
                                n_state = ST_EMIT;
                            end else begin
                                n_state = ST_RO_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_st    = STAT_OK;
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_st    = STAT_OK;
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            // First scan: grow the working range over every touching entry
            ST_P1_RD: begin
                if (r_i < r_count) begin
                    rd_en   = 1'b1;
                    n_state = ST_P1_EV;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_P1_EV: begin
                if (mres.touch) begin
                    n_cur_s    = mrg_s;
                    n_cur_e    = mrg_e;
                    n_absorbed = 1'b1;
                end
                n_i     = r_i + CNT_W'(1);
                n_state = ST_P1_RD;
            end
            ST_DECIDE: begin
                if (!r_absorbed && (r_count >= CNT_W'(TABLE_DEPTH))) begin
                    n_st    = STAT_FULL;
                    n_state = ST_EMIT;
                end else begin
                    n_i        = '0;
                    n_w        = '0;
                    n_inserted = 1'b0;
                    n_state    = ST_P2_RD;
                end
            end
            // Second scan: copy kept entries and the merged one into the other bank
            ST_P2_RD: begin
                if (r_i < r_count) begin
                    rd_en   = 1'b1;
                    n_state = ST_P2_EV;
                end else begin
                    if (!r_inserted) begin
                        wr_en = 1'b1;
                        n_w   = r_w + CNT_W'(1);
                    end
                    n_state = ST_FINISH;
                end
            end
            ST_P2_EV: begin
                if (mres.touch) begin
                    // drop an absorbed entry
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_P2_RD;
                end else if (!r_inserted && !mres.ent_lt) begin
                    // place the merged range first, keep the read data
                    wr_en      = 1'b1;
                    n_w        = r_w + CNT_W'(1);
                    n_inserted = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_w     = r_w + CNT_W'(1);
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_P2_RD;
                end
            end
            ST_FINISH: begin
                n_bank  = ~r_bank;
                n_count = r_w;
                n_st    = STAT_OK;
                n_state = ST_EMIT;
            end
            // Readout: one result per stored range
            ST_RO_RD: begin
                rd_en   = 1'b1;
                n_state = ST_RO_EV;
            end
            ST_RO_EV: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_st    = STAT_OK;
                    n_o_start = ent_s;
                    n_o_len   = ent_e - ent_s;
                    n_o_last  = ro_last;
                    n_o_used  = USED_W'(r_count);
                    n_i       = r_i + CNT_W'(1);
                    n_state   = ro_last ? ST_IDLE : ST_RO_RD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_st    = r_st;
                    n_o_start = '0;
                    n_o_len   = '0;
                    n_o_last  = 1'b1;
                    n_o_used  = USED_W'(r_count);
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bank    <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bank    <= n_bank;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_i        <= n_i;
        r_w        <= n_w;
        r_cur_s    <= n_cur_s;
        r_cur_e    <= n_cur_e;
        r_absorbed <= n_absorbed;
        r_inserted <= n_inserted;
        r_st       <= n_st;
        r_o_st     <= n_o_st;
        r_o_start  <= n_o_start;
        r_o_len    <= n_o_len;
        r_o_last   <= n_o_last;
        r_o_used   <= n_o_used;
    end

    // Drive the master side
    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_st;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_o_used, r_o_len, r_o_start};

    // Checks on the sequencer
    `IMT_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(TABLE_DEPTH),
                       "entry count exceeds depth")
    `IMT_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready,
                     "ready after accept")
    `IMT_ASSERT_SAME(a_copy_ptr,
                     (r_state == ST_P2_RD || r_state == ST_P2_EV) && r_i < r_count,
                     r_w <= r_i + CNT_W'(1), "copy pointer ran ahead")
    `IMT_ASSERT_SAME(a_empty_zero, o_m_tvalid && o_m_tuser == STAT_EMPTY,
                     o_m_tdata[2*ADDR_W-1:0] == '0 && o_m_tlast,
                     "empty readout carries data")

endmodule
